// ===== design/flow_frame_parser_unit_assert.svh =====
// assertion macros for the checker file ffp_checker.sv
`ifndef FLOW_FRAME_PARSER_UNIT_ASSERT_SVH
`define FLOW_FRAME_PARSER_UNIT_ASSERT_SVH

// checked at every edge outside reset
`define FFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define FFP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/ffp_pkg.sv =====
// shared constants and types of the flow frame parser
package ffp_pkg;

  localparam logic [7:0] HDR0_BYTE = 8'h55;
  localparam logic [7:0] HDR1_BYTE = 8'hAA;
  localparam logic [7:0] SEP_BYTE  = 8'h7C;
  localparam logic [7:0] CR_BYTE   = 8'h0D;
  localparam logic [7:0] LF_BYTE   = 8'h0A;

  typedef enum logic [10:0] {
    POS_HUNT = 11'b000_0000_0001,
    POS_HDR1 = 11'b000_0000_0010,
    POS_XLO  = 11'b000_0000_0100,
    POS_XHI  = 11'b000_0000_1000,
    POS_SEP1 = 11'b000_0001_0000,
    POS_YLO  = 11'b000_0010_0000,
    POS_YHI  = 11'b000_0100_0000,
    POS_SEP2 = 11'b000_1000_0000,
    POS_LAND = 11'b001_0000_0000,
    POS_CR   = 11'b010_0000_0000,
    POS_LF   = 11'b100_0000_0000
  } frame_pos_t;

  typedef struct packed {
    logic signed [15:0] flow_x;
    logic signed [15:0] flow_y;
    logic        [7:0]  land_code;
  } flow_result_t;

endpackage

// ===== design/flow_frame_parser_unit.sv =====
// flow frame parser: byte stream in, one flow result per complete frame out
//
// input channel: in_valid / in_stall carry one received byte (in_rx_byte) per
// transfer. output channel: out_valid / out_stall carry out_flow_x, out_flow_y
// (signed, little endian from the frame) and out_land_code.
// a frame is 55 aa xl xh '|' yl yh '|' land cr lf; any bad header, separator or
// terminator byte drops back to hunting for 55. the lf byte produces the result.
// throughput: one byte per cycle unless in_stall holds an lf byte, set by the
// position update between the input register and the result register.
// order: a taken byte waits in the input register and is parsed from there; the
// result of an lf byte passes the input register and then the result register.
// stall: a waiting result holds in the output register while non-result bytes
// keep flowing; in_stall rises only when an lf byte finds the result still held.
// reset (rst_n low, synchronous) empties both registers and resumes the hunt.
module flow_frame_parser_unit
  import ffp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_flow_x,
  output logic signed [15:0] out_flow_y,
  output logic [7:0]         out_land_code
);

  logic         byte_valid;
  logic [7:0]   byte_data;
  logic         frame_hit;
  logic         out_free;
  logic         step_en;
  flow_result_t result;

  // a byte steps unless its result has nowhere to go
  assign step_en = byte_valid && (!frame_hit || out_free);

  ffp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .in_stall   (in_stall),
    .step_en    (step_en),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  ffp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .byte_data (byte_data),
    .frame_hit (frame_hit),
    .result    (result)
  );

  ffp_out_stage u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (step_en && frame_hit),
    .result        (result),
    .out_free      (out_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_flow_x    (out_flow_x),
    .out_flow_y    (out_flow_y),
    .out_land_code (out_land_code)
  );

endmodule

// ===== design/ffp_in_stage.sv =====
// input register for received bytes
module ffp_in_stage
  import ffp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_rx_byte,
  output logic       in_stall,
  input  logic       step_en,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       take;

  assign in_stall  = valid_r && !step_en;
  assign take      = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (step_en) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_rx_byte;
    end
  end

  assign byte_valid = valid_r;
  assign byte_data  = byte_r;

endmodule

// ===== design/ffp_parser.sv =====
// frame position tracking and payload capture
module ffp_parser
  import ffp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step_en,
  input  logic [7:0]   byte_data,
  output logic         frame_hit,
  output flow_result_t result
);

  frame_pos_t pos_r;
  frame_pos_t pos_nxt;
  logic [7:0] xlo_r;
  logic [7:0] xhi_r;
  logic [7:0] ylo_r;
  logic [7:0] yhi_r;
  logic [7:0] land_r;

  always_comb begin
    pos_nxt = POS_HUNT;
    unique case (pos_r)
      POS_HUNT: pos_nxt = (byte_data == HDR0_BYTE) ? POS_HDR1 : POS_HUNT;
      POS_HDR1: pos_nxt = (byte_data == HDR1_BYTE) ? POS_XLO : POS_HUNT;
      POS_XLO:  pos_nxt = POS_XHI;
      POS_XHI:  pos_nxt = POS_SEP1;
      POS_SEP1: pos_nxt = (byte_data == SEP_BYTE) ? POS_YLO : POS_HUNT;
      POS_YLO:  pos_nxt = POS_YHI;
      POS_YHI:  pos_nxt = POS_SEP2;
      POS_SEP2: pos_nxt = (byte_data == SEP_BYTE) ? POS_LAND : POS_HUNT;
      POS_LAND: pos_nxt = POS_CR;
      POS_CR:   pos_nxt = (byte_data == CR_BYTE) ? POS_LF : POS_HUNT;
      POS_LF:   pos_nxt = POS_HUNT;
      default:  pos_nxt = POS_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_HUNT;
    end else if (step_en) begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      if (pos_r == POS_XLO) begin
        xlo_r <= byte_data;
      end
      if (pos_r == POS_XHI) begin
        xhi_r <= byte_data;
      end
      if (pos_r == POS_YLO) begin
        ylo_r <= byte_data;
      end
      if (pos_r == POS_YHI) begin
        yhi_r <= byte_data;
      end
      if (pos_r == POS_LAND) begin
        land_r <= byte_data;
      end
    end
  end

  // the lf byte itself closes the frame
  assign frame_hit        = (pos_r == POS_LF) && (byte_data == LF_BYTE);
  assign result.flow_x    = {xhi_r, xlo_r};
  assign result.flow_y    = {yhi_r, ylo_r};
  assign result.land_code = land_r;

endmodule

// ===== design/ffp_out_stage.sv =====
// result register toward the receiver
module ffp_out_stage
  import ffp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  flow_result_t       result,
  output logic               out_free,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_flow_x,
  output logic signed [15:0] out_flow_y,
  output logic [7:0]         out_land_code
);

  logic         valid_r;
  logic         valid_nxt;
  flow_result_t data_r;

  assign out_free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_valid     = valid_r;
  assign out_flow_x    = data_r.flow_x;
  assign out_flow_y    = data_r.flow_y;
  assign out_land_code = data_r.land_code;

endmodule

// ===== design/ffp_checker.sv =====
// port-level checker for the flow frame parser, bound to the top level
`include "flow_frame_parser_unit_assert.svh"

module ffp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_rx_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_flow_x,
  input logic [15:0] out_flow_y,
  input logic [7:0]  out_land_code
);

  logic [39:0] out_bus;

  assign out_bus = {out_flow_x, out_flow_y, out_land_code};

  `FFP_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "out_valid after reset")
  `FFP_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_bus), "result lost")
  `FFP_ASSERT(a_in_stall_cause, in_stall |-> out_valid && out_stall, "input stalled, output free")
  `FFP_ASSERT(a_new_result_src, $rose(out_valid) |-> !$past(in_stall), "result from blocked byte")
  `FFP_ASSERT(a_in_hold, in_valid && in_stall |=> $stable(in_rx_byte), "stalled byte moved")

endmodule

bind flow_frame_parser_unit ffp_checker u_ffp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_rx_byte    (in_rx_byte),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_flow_x    (out_flow_x),
  .out_flow_y    (out_flow_y),
  .out_land_code (out_land_code)
);
